FILE: rtl/core/modulated_comb_reverb_core_assert.svh
// ----------------------------------------------------------------------------
// modulated_comb_reverb_core_assert.svh
// Assertion macros for the modulated comb reverb core. They use the clk and
// rst_n signals of the module that includes this header.
// ----------------------------------------------------------------------------
`ifndef MODULATED_COMB_REVERB_CORE_ASSERT_SVH
`define MODULATED_COMB_REVERB_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition holds at every clock edge out of reset
`define MCR_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("invariant check failed");

// Consequent holds in the same cycle as the antecedent
`define MCR_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Consequent holds in the cycle after the antecedent
`define MCR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`else

`define MCR_ASSERT_ALWAYS(label, cond)
`define MCR_ASSERT_IMPLIES(label, ante, cons)
`define MCR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: rtl/core/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared widths, register codes, reset values, the quarter-wave sine table
// and the saturation helper of the modulated comb reverb core.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // Delay store geometry
    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
    localparam int FILL_BITS   = ADDR_BITS + 1;

    // Sample and gain formats
    localparam int SAMPLE_BITS = 16;
    localparam int GAIN_BITS   = 16;
    localparam int DEPTH_BITS  = 4;
    localparam int PHASE_BITS  = 32;
    localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int SUM_BITS    = PROD_BITS + 1;
    localparam int WIDE_BITS   = SAMPLE_BITS + 2;

    // Sine table: one turn of SINE_ENTRIES, stored as one quarter
    localparam int SINE_ENTRIES  = 1024;
    localparam int SINE_IDX_BITS = $clog2(SINE_ENTRIES);
    localparam int QTR_ENTRIES   = SINE_ENTRIES / 4;
    localparam int QTR_BITS      = SINE_IDX_BITS - 2;
    localparam int SINE_MAG_BITS = 15;
    localparam logic [SINE_MAG_BITS-1:0] SINE_FULL = {SINE_MAG_BITS{1'b1}};

    // Configuration port
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TAP_DISTANCE   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FEEDBACK_GAIN  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DRY_GAIN       = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WET_GAIN       = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOD_DEPTH      = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOD_PHASE_STEP = 3'd5;

    // Register reset values
    localparam logic [15:0]           TAP_RESET        = 16'd16381;
    localparam logic [GAIN_BITS-1:0]  FEEDBACK_RESET   = 16'd25840;
    localparam logic [GAIN_BITS-1:0]  DRY_RESET        = 16'd39322;
    localparam logic [GAIN_BITS-1:0]  WET_RESET        = 16'd26214;
    localparam logic [DEPTH_BITS-1:0] DEPTH_RESET      = 4'd12;
    localparam logic [PHASE_BITS-1:0] PHASE_STEP_RESET = 32'd1367405;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [WIDE_BITS-1:0]   wide_t;
    typedef logic [SINE_MAG_BITS-1:0]      sine_qtr_t [QTR_ENTRIES];

    // Quarter-wave sine magnitudes in unsigned Q0.15, Taylor series in Q30
    function automatic sine_qtr_t build_sine_qtr();
        sine_qtr_t   tab;
        logic [63:0] w;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] q30_one;
        logic [63:0] half_pi;
        q30_one = 64'd1 << 30;
        half_pi = 64'd1686629713;
        for (int k = 0; k < QTR_ENTRIES; k++)
        begin
            w  = 64'(k) << (30 - QTR_BITS);
            x  = (w * half_pi) >> 30;
            x2 = (x * x) >> 30;
            t  = q30_one - x2 / 64'd110;
            t  = q30_one - ((x2 * t) >> 30) / 64'd72;
            t  = q30_one - ((x2 * t) >> 30) / 64'd42;
            t  = q30_one - ((x2 * t) >> 30) / 64'd20;
            t  = q30_one - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            r  = (s + (64'd1 << 14)) >> 15;
            if (r > 64'd32767)
            begin
                r = 64'd32767;
            end
            tab[k] = r[SINE_MAG_BITS-1:0];
        end
        return tab;
    endfunction

    localparam sine_qtr_t SINE_QTR = build_sine_qtr();

    // Clamp a widened value back to the sample range
    function automatic sample_t saturate(input wide_t v);
        logic    ovf_hi;
        logic    ovf_lo;
        sample_t res;
        ovf_hi = !v[WIDE_BITS-1] && (v[WIDE_BITS-2:SAMPLE_BITS-1] != '0);
        ovf_lo = v[WIDE_BITS-1] && (v[WIDE_BITS-2:SAMPLE_BITS-1] != '1);
        if (ovf_hi)
        begin
            res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        else if (ovf_lo)
        begin
            res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            res = v[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/mcr_if.sv
// ----------------------------------------------------------------------------
// mcr_if
// Valid/ready stream channels of the reverb core: stereo input items and
// stereo result items.
// ----------------------------------------------------------------------------
interface mcr_in_if;
    import mcr_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_in;
    sample_t right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface mcr_out_if;
    import mcr_pkg::*;

    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

FILE: rtl/core/modulated_comb_reverb_core.sv
// Each item runs a four-step sequence (accept, store read, echo products,
// write-back); the result item is registered at write-back, and a new input
// item is taken only once the last one is written back. A stalled output holds
// the write-back step.
// Reset: registers return to their defaults, write pointer and phase to zero;
// a fill count makes never-written store entries read as zero, so there is
// no clearing pass and the block takes items right after reset.
// ----------------------------------------------------------------------------
// modulated_comb_reverb_core
// Stereo modulated feedback comb filter: a sine-modulated tap into a delay
// memory, left input plus scaled echo written back, dry/wet output mix.
// ----------------------------------------------------------------------------
`include "modulated_comb_reverb_core_assert.svh"

module modulated_comb_reverb_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mcr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [mcr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    mcr_in_if.sink                             in_ch,
    mcr_out_if.source                          out_ch
);
    import mcr_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADDR = 2'd1;
    localparam logic [1:0] ST_MULT = 2'd2;
    localparam logic [1:0] ST_WB   = 2'd3;

    // Configuration registers
    logic [15:0]           tap_reg;
    logic [GAIN_BITS-1:0]  fb_gain_reg;
    logic [GAIN_BITS-1:0]  dry_gain_reg;
    logic [GAIN_BITS-1:0]  wet_gain_reg;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic [PHASE_BITS-1:0] step_reg;

    // Control state
    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [ADDR_BITS-1:0]  wp_reg;
    logic [ADDR_BITS-1:0]  wp_next;
    logic [FILL_BITS-1:0]  fill_reg;
    logic [FILL_BITS-1:0]  fill_next;
    logic [PHASE_BITS-1:0] phase_reg;
    logic [PHASE_BITS-1:0] phase_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // Per-item payload
    sample_t                  left_reg;
    sample_t                  right_reg;
    logic [SINE_MAG_BITS-1:0] sine_mag_reg;
    logic                     sine_neg_reg;
    logic                     rd_valid_reg;
    logic signed [PROD_BITS-1:0] dry_l_reg;
    logic signed [PROD_BITS-1:0] dry_r_reg;
    logic signed [PROD_BITS-1:0] fb_prod_reg;
    logic signed [PROD_BITS-1:0] wet_prod_reg;
    sample_t                  left_out_reg;
    sample_t                  right_out_reg;

    logic                     in_accept;
    logic                     wb_go;
    logic [1:0]               quad;
    logic [QTR_BITS-1:0]      qtr_idx;
    logic [QTR_BITS-1:0]      qtr_mir;
    logic [SINE_MAG_BITS-1:0] sine_mag;
    logic [SINE_MAG_BITS+DEPTH_BITS-1:0] off_prod;
    logic [DEPTH_BITS-1:0]    off_mag;
    logic [ADDR_BITS-1:0]     off_ext;
    logic [ADDR_BITS-1:0]     base_addr;
    logic [ADDR_BITS-1:0]     rd_addr;
    logic                     rd_in_fill;
    logic [SAMPLE_BITS-1:0]   ram_rdata;
    sample_t                  echo;
    logic [SUM_BITS-1:0]      sum_l;
    logic [SUM_BITS-1:0]      sum_r;
    logic [WIDE_BITS-1:0]     fb_sum;
    sample_t                  store_wdata;
    sample_t                  left_mix;
    sample_t                  right_mix;

    // Handshake
    assign in_ch.ready      = (state_reg == ST_IDLE);
    assign in_accept        = in_ch.valid && in_ch.ready;
    assign wb_go            = (state_reg == ST_WB) && (!out_valid_reg || out_ch.ready);
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.left_out  = left_out_reg;
    assign out_ch.right_out = right_out_reg;

    // Quarter-wave sine lookup from the current phase
    assign quad    = phase_reg[PHASE_BITS-1 -: 2];
    assign qtr_idx = phase_reg[PHASE_BITS-3 -: QTR_BITS];
    assign qtr_mir = ~qtr_idx + QTR_BITS'(1);

    always_comb
    begin
        if (quad[0] && (qtr_idx == '0))
        begin
            sine_mag = SINE_FULL;
        end
        else if (quad[0])
        begin
            sine_mag = SINE_QTR[qtr_mir];
        end
        else
        begin
            sine_mag = SINE_QTR[qtr_idx];
        end
    end

    // Read address: pointer minus tap, plus signed modulation offset
    assign off_prod   = {{DEPTH_BITS{1'b0}}, sine_mag_reg} *
                        {{SINE_MAG_BITS{1'b0}}, depth_reg};
    assign off_mag    = off_prod[SINE_MAG_BITS+DEPTH_BITS-1:SINE_MAG_BITS];
    assign off_ext    = {{(ADDR_BITS-DEPTH_BITS){1'b0}}, off_mag};
    assign base_addr  = wp_reg - tap_reg[ADDR_BITS-1:0];
    assign rd_addr    = sine_neg_reg ? (base_addr - off_ext) : (base_addr + off_ext);
    assign rd_in_fill = ({1'b0, rd_addr} < fill_reg);

    // Entries never written read as zero
    assign echo = rd_valid_reg ? sample_t'(ram_rdata) : '0;

    // Output mix and feedback write value, floor shift then saturate
    assign sum_l = {dry_l_reg[PROD_BITS-1], dry_l_reg} +
                   {wet_prod_reg[PROD_BITS-1], wet_prod_reg};
    assign sum_r = {dry_r_reg[PROD_BITS-1], dry_r_reg} +
                   {wet_prod_reg[PROD_BITS-1], wet_prod_reg};
    assign fb_sum = {fb_prod_reg[PROD_BITS-1], fb_prod_reg[PROD_BITS-1:GAIN_BITS]} +
                    {{2{left_reg[SAMPLE_BITS-1]}}, left_reg};
    assign left_mix    = saturate(wide_t'(sum_l[SUM_BITS-1:GAIN_BITS]));
    assign right_mix   = saturate(wide_t'(sum_r[SUM_BITS-1:GAIN_BITS]));
    assign store_wdata = saturate(wide_t'(fb_sum));

    mcr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (wb_go),
        .waddr (wp_reg),
        .wdata (store_wdata),
        .re    (state_reg == ST_ADDR),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Sequencer and pointer update
    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    phase_next = phase_reg + step_reg;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                state_next = ST_MULT;
            end
            ST_MULT:
            begin
                state_next = ST_WB;
            end
            ST_WB:
            begin
                if (wb_go)
                begin
                    wp_next        = wp_reg + ADDR_BITS'(1);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (fill_reg != FILL_BITS'(STORE_DEPTH))
                    begin
                        fill_next = fill_reg + FILL_BITS'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg      <= TAP_RESET;
            fb_gain_reg  <= FEEDBACK_RESET;
            dry_gain_reg <= DRY_RESET;
            wet_gain_reg <= WET_RESET;
            depth_reg    <= DEPTH_RESET;
            step_reg     <= PHASE_STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TAP_DISTANCE:   tap_reg      <= cfg_wdata[15:0];
                CFG_FEEDBACK_GAIN:  fb_gain_reg  <= cfg_wdata[GAIN_BITS-1:0];
                CFG_DRY_GAIN:       dry_gain_reg <= cfg_wdata[GAIN_BITS-1:0];
                CFG_WET_GAIN:       wet_gain_reg <= cfg_wdata[GAIN_BITS-1:0];
                CFG_MOD_DEPTH:      depth_reg    <= cfg_wdata[DEPTH_BITS-1:0];
                CFG_MOD_PHASE_STEP: step_reg     <= cfg_wdata[PHASE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Item datapath: latch, address and dry products, echo products, result
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            left_reg     <= in_ch.left_in;
            right_reg    <= in_ch.right_in;
            sine_mag_reg <= sine_mag;
            sine_neg_reg <= quad[1];
        end
        if (state_reg == ST_ADDR)
        begin
            rd_valid_reg <= rd_in_fill;
            dry_l_reg    <= left_reg * $signed({1'b0, dry_gain_reg});
            dry_r_reg    <= right_reg * $signed({1'b0, dry_gain_reg});
        end
        if (state_reg == ST_MULT)
        begin
            fb_prod_reg  <= echo * $signed({1'b0, fb_gain_reg});
            wet_prod_reg <= echo * $signed({1'b0, wet_gain_reg});
        end
        if (wb_go)
        begin
            left_out_reg  <= left_mix;
            right_out_reg <= right_mix;
        end
    end

    // Checks
    `MCR_ASSERT_ALWAYS(a_fill_bound, fill_reg <= FILL_BITS'(STORE_DEPTH))
    `MCR_ASSERT_IMPLIES(a_wp_tracks_fill, fill_reg != FILL_BITS'(STORE_DEPTH), wp_reg == fill_reg[ADDR_BITS-1:0])
    `MCR_ASSERT_NEXT(a_wb_advances, wb_go, out_valid_reg && (wp_reg == ADDR_BITS'($past(wp_reg) + 1'b1)))
    `MCR_ASSERT_IMPLIES(a_out_from_wb, $rose(out_valid_reg), $past(state_reg) == ST_WB)

endmodule

FILE: rtl/core/mcr_ram.sv
// ----------------------------------------------------------------------------
// mcr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mcr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/modulated_comb_reverb_core_test.sv
// ----------------------------------------------------------------------------
// modulated_comb_reverb_core_test
// Self-checking bench for the modulated comb reverb core. A directed table
// covers sample extremes, register masking, spare register indexes, zero and
// maximal tap distances and full-scale gains. It is followed by randomized
// phases with fresh register settings. Every result item is checked against
// a cycle-free model of the delay store, the sine modulation and the mix.
// ----------------------------------------------------------------------------
module modulated_comb_reverb_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mcr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_PHASES  = 10;
    localparam int SETTLE_CYCLES = 8;

    // Spare register indexes: writes there must change nothing
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 3'd7;

    localparam sample_t S_MAX = 16'sh7FFF;
    localparam sample_t S_MIN = 16'sh8000;

    typedef struct packed {
        sample_t left;
        sample_t right;
    } out_pair_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ITEM,
        ROW_KNOWN
    } row_kind_e;

    typedef struct packed {
        row_kind_e                kind;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] data;
        sample_t                  left;
        sample_t                  right;
        sample_t                  exp_left;
        sample_t                  exp_right;
    } dir_row_t;

    localparam int DIR_ROWS = 39;

    // Directed stimulus; known rows carry results that follow from reset
    // (the tap points far back into never-written store entries)
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{ROW_KNOWN, CFG_TAP_DISTANCE, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_KNOWN, CFG_TAP_DISTANCE, 32'h0, S_MAX, S_MIN, 16'sd19660, -16'sd19661},
        '{ROW_KNOWN, CFG_TAP_DISTANCE, 32'h0, S_MIN, S_MAX, -16'sd19661, 16'sd19660},
        '{ROW_KNOWN, CFG_TAP_DISTANCE, 32'h0, 16'sd1, -16'sd1, 16'sd0, -16'sd1},
        // Short tap, full feedback and wet, no modulation
        '{ROW_CFG, CFG_TAP_DISTANCE, 32'd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_FEEDBACK_GAIN, 32'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_DRY_GAIN, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_WET_GAIN, 32'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_MOD_DEPTH, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_MOD_PHASE_STEP, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, 16'sd1000, -16'sd5, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, -16'sd5, 16'sd7, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, S_MAX, S_MAX, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, S_MAX, S_MIN, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, S_MIN, S_MIN, 16'sd0, 16'sd0},
        // Zero tap through masking: read the entry about to be overwritten
        '{ROW_CFG, CFG_TAP_DISTANCE, 32'h0001_0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, 16'sd1234, -16'sd4321, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, S_MIN, S_MAX, 16'sd0, 16'sd0},
        // Masked tap, spare indexes, deep quarter-turn modulation
        '{ROW_CFG, CFG_TAP_DISTANCE, 32'h0003_0003, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_SPARE_A, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_SPARE_B, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_MOD_DEPTH, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_MOD_PHASE_STEP, 32'h4000_0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_DRY_GAIN, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, S_MAX, S_MIN, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, S_MIN, S_MAX, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, -16'sd1, 16'sd1, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, 16'sd16384, -16'sd16384, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, S_MAX, S_MAX, 16'sd0, 16'sd0},
        // Longest tap, no feedback, phase step one tick short of a turn
        '{ROW_CFG, CFG_MOD_PHASE_STEP, 32'hFFFF_FFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_FEEDBACK_GAIN, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_TAP_DISTANCE, 32'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_WET_GAIN, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, S_MIN, S_MIN, 16'sd0, 16'sd0},
        '{ROW_CFG, CFG_WET_GAIN, 32'hFFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, 16'sd77, -16'sd77, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, S_MAX, 16'sd0, 16'sd0, 16'sd0},
        '{ROW_ITEM, CFG_TAP_DISTANCE, 32'h0, 16'sd0, S_MIN, 16'sd0, 16'sd0}
    };

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    mcr_in_if  in_ch ();
    mcr_out_if out_ch ();

    modulated_comb_reverb_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Model state: delay store, pointer, phase and register copies
    sample_t                echo_mem [STORE_DEPTH];
    logic [ADDR_BITS-1:0]   wr_ptr;
    logic [PHASE_BITS-1:0]  mod_phase;
    sample_t                sine_lut [SINE_ENTRIES];
    logic [15:0]            tap_dist;
    logic [GAIN_BITS-1:0]   fb_gain;
    logic [GAIN_BITS-1:0]   dry_mix;
    logic [GAIN_BITS-1:0]   wet_mix;
    logic [DEPTH_BITS-1:0]  mod_depth;
    logic [PHASE_BITS-1:0]  phase_step;

    out_pair_t result_q [$];
    out_pair_t head_exp;
    int        errors;
    int        cycle_count;
    int        burst_left;
    int        rx_window;
    int        rx_mode;

    // Full-turn sine in Q1.15 via a Q30 Taylor series, half-up rounding
    function automatic sample_t sine_value(int k);
        logic [63:0] u;
        logic [63:0] w;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] one_q30;
        logic [1:0]  quad;
        one_q30 = 64'd1 << 30;
        u = (64'(k) << 32) / 64'(SINE_ENTRIES);
        quad = u[31:30];
        w = u & (one_q30 - 64'd1);
        if (quad[0])
        begin
            w = one_q30 - w;
        end
        x  = (w * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t  = one_q30 - x2 / 64'd110;
        t  = one_q30 - ((x2 * t) >> 30) / 64'd72;
        t  = one_q30 - ((x2 * t) >> 30) / 64'd42;
        t  = one_q30 - ((x2 * t) >> 30) / 64'd20;
        t  = one_q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        r  = (s + (64'd1 << 14)) >> 15;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return quad[1] ? -sample_t'(r[15:0]) : sample_t'(r[15:0]);
    endfunction

    function automatic sample_t clamp_sample(longint v);
        if (v > longint'(S_MAX))
        begin
            return S_MAX;
        end
        if (v < longint'(S_MIN))
        begin
            return S_MIN;
        end
        return sample_t'(v);
    endfunction

    // Advance the comb model by one item: read, write back, then mix
    function automatic out_pair_t reverb_step(sample_t l, sample_t r);
        out_pair_t            res;
        logic [ADDR_BITS-1:0] rd;
        int                   sv;
        int                   mag;
        int                   off;
        longint               echo;
        longint               fed;
        sv  = int'(sine_lut[(64'(mod_phase) * 64'(SINE_ENTRIES)) >> 32]);
        mag = ((sv < 0 ? -sv : sv) * int'(mod_depth)) >> 15;
        off = (sv < 0) ? -mag : mag;
        rd  = wr_ptr - tap_dist + ADDR_BITS'(off);
        echo = longint'(echo_mem[rd]);
        fed  = longint'(l) + ((echo * longint'(fb_gain)) >>> 16);
        echo_mem[wr_ptr] = clamp_sample(fed);
        wr_ptr    = wr_ptr + 1'b1;
        mod_phase = mod_phase + phase_step;
        res.left  = clamp_sample((longint'(l) * longint'(dry_mix) +
                                  echo * longint'(wet_mix)) >>> 16);
        res.right = clamp_sample((longint'(r) * longint'(dry_mix) +
                                  echo * longint'(wet_mix)) >>> 16);
        return res;
    endfunction

    // Write one register and mirror it, masked to its width
    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= d;
        case (idx)
            CFG_TAP_DISTANCE:   tap_dist   = d[15:0];
            CFG_FEEDBACK_GAIN:  fb_gain    = d[GAIN_BITS-1:0];
            CFG_DRY_GAIN:       dry_mix    = d[GAIN_BITS-1:0];
            CFG_WET_GAIN:       wet_mix    = d[GAIN_BITS-1:0];
            CFG_MOD_DEPTH:      mod_depth  = d[DEPTH_BITS-1:0];
            CFG_MOD_PHASE_STEP: phase_step = d[PHASE_BITS-1:0];
            default:            ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, drain all results and let the write-back finish
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (result_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Offer one item, hold until accepted, then idle per burst pattern
    task automatic send_item(sample_t l, sample_t r, bit known, sample_t kl, sample_t kr);
        out_pair_t want;
        int        gap;
        in_ch.valid    <= 1'b1;
        in_ch.left_in  <= l;
        in_ch.right_in <= r;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        want = reverb_step(l, r);
        if (known)
        begin
            want.left  = kl;
            want.right = kr;
        end
        result_q.push_back(want);
        if ($urandom_range(0, 299) == 0)
        begin
            // hold off until every pending result is out
            in_ch.valid <= 1'b0;
            while (result_q.size() != 0)
            begin
                @(posedge clk);
            end
        end
        else
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
                if (gap > 0)
                begin
                    in_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    function automatic sample_t pick_sample();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 14)
        begin
            return sample_t'($urandom);
        end
        if (pick < 17)
        begin
            return sample_t'($urandom_range(0, 1023)) - 16'sd512;
        end
        case ($urandom_range(0, 4))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return 16'sd0;
            3:       return -16'sd1;
            default: return 16'sd1;
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] pick_gain();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 3)
        begin
            return '0;
        end
        if (pick < 6)
        begin
            return '1;
        end
        return GAIN_BITS'($urandom);
    endfunction

    // Fresh register set for a random phase, junk in the unused upper bits
    task automatic program_phase();
        logic [15:0]           tap;
        logic [PHASE_BITS-1:0] step;
        int                    pick;
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            tap = 16'($urandom_range(1, 64));
        end
        else if (pick < 8)
        begin
            tap = 16'($urandom_range(65, 2000));
        end
        else if (pick == 8)
        begin
            tap = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1;
        end
        else
        begin
            tap = 16'($urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            step = '0;
        end
        else if (pick < 3)
        begin
            step = '1;
        end
        else if (pick < 6)
        begin
            step = $urandom;
        end
        else
        begin
            step = $urandom_range(0, 32'h0400_0000);
        end
        settle();
        cfg_write(CFG_TAP_DISTANCE, {16'($urandom), tap});
        cfg_write(CFG_FEEDBACK_GAIN, {16'($urandom), pick_gain()});
        cfg_write(CFG_DRY_GAIN, {16'($urandom), pick_gain()});
        cfg_write(CFG_WET_GAIN, {16'($urandom), pick_gain()});
        cfg_write(CFG_MOD_DEPTH, {28'($urandom), 4'($urandom)});
        cfg_write(CFG_MOD_PHASE_STEP, step);
        if ($urandom_range(0, 2) == 0)
        begin
            cfg_write(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL modulated_comb_reverb_core");
            $finish;
        end
    end

    // Result receiver: stall pattern changes every window
    initial
    begin
        out_ch.ready <= 1'b0;
        rx_window = 0;
        rx_mode   = 0;
        forever
        begin
            @(posedge clk);
            if (rx_window == 0)
            begin
                rx_mode = $urandom_range(0, 3);
            end
            rx_window = (rx_window + 1) % 48;
            case (rx_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= ($urandom_range(0, 1) != 0);
                2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= (rx_window >= 24);
            endcase
        end
    end

    // Compare each accepted result item with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (result_q.size() == 0)
            begin
                $display("%0t: unexpected result item: expected none, actual left %0d right %0d",
                         $time, out_ch.left_out, out_ch.right_out);
                errors++;
            end
            else
            begin
                head_exp = result_q.pop_front();
                if (out_ch.left_out !== head_exp.left)
                begin
                    $display("%0t: left_out mismatch: expected %0d, actual %0d",
                             $time, head_exp.left, out_ch.left_out);
                    errors++;
                end
                if (out_ch.right_out !== head_exp.right)
                begin
                    $display("%0t: right_out mismatch: expected %0d, actual %0d",
                             $time, head_exp.right, out_ch.right_out);
                    errors++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_TAP_DISTANCE;
        cfg_wdata      <= '0;
        in_ch.valid    <= 1'b0;
        in_ch.left_in  <= '0;
        in_ch.right_in <= '0;
        burst_left  = 1;

        // Model reset state
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            echo_mem[i] = '0;
        end
        for (int k = 0; k < SINE_ENTRIES; k++)
        begin
            sine_lut[k] = sine_value(k);
        end
        wr_ptr     = '0;
        mod_phase  = '0;
        tap_dist   = TAP_RESET;
        fb_gain    = FEEDBACK_RESET;
        dry_mix    = DRY_RESET;
        wet_mix    = WET_RESET;
        mod_depth  = DEPTH_RESET;
        phase_step = PHASE_STEP_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TAB[i].kind == ROW_CFG)
            begin
                settle();
                cfg_write(DIR_TAB[i].idx, DIR_TAB[i].data);
            end
            else
            begin
                send_item(DIR_TAB[i].left, DIR_TAB[i].right, DIR_TAB[i].kind == ROW_KNOWN,
                          DIR_TAB[i].exp_left, DIR_TAB[i].exp_right);
            end
        end

        // Random phases
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            program_phase();
            repeat ($urandom_range(120, 160))
            begin
                send_item(pick_sample(), pick_sample(), 1'b0, '0, '0);
            end
        end

        // Drain and let any stray result show up
        in_ch.valid <= 1'b0;
        while (result_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (20) @(posedge clk);
        if (errors == 0)
        begin
            $display("PASS modulated_comb_reverb_core");
        end
        else
        begin
            $display("FAIL modulated_comb_reverb_core");
        end
        $finish;
    end

endmodule
